// File: rtl/core/rmms_pkg.sv
`timescale 1ns / 1ps

package rmms_pkg;

  localparam int RPM_W       = 14;
  localparam int SPEED_W     = 8;
  localparam int GEAR_W      = 3;
  localparam int TARGET_W    = 16;
  localparam int RATIO_W     = 8;
  localparam int ID_W        = 11;
  localparam int BYTE_W      = 8;
  localparam int NUM_BYTES   = 8;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_W       = 14;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIV_STEPS   = RPM_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [GEAR_W-1:0] GEAR_FLOOR_RESET = 3'd2;
  localparam logic [RPM_W-1:0]  MAX_RPM_RESET    = 14'd5000;

  localparam logic [CFG_IDX_W-1:0] CFG_GEAR_FLOOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RPM    = 1'b1;

  localparam logic [ID_W-1:0] ID_ENGINE  = 11'h110;
  localparam logic [ID_W-1:0] ID_SPEED   = 11'h410;
  localparam logic [ID_W-1:0] ID_CLUTCH  = 11'h300;
  localparam logic [ID_W-1:0] ID_BUTTONS = 11'h175;
  localparam logic [ID_W-1:0] ID_DOORS   = 11'h135;

  localparam logic [BYTE_W-1:0] BTN_UP_B5 = 8'h10;
  localparam logic [BYTE_W-1:0] BTN_UP_B6 = 8'h1F;
  localparam logic [BYTE_W-1:0] BTN_DN_B5 = 8'h20;
  localparam logic [BYTE_W-1:0] BTN_DN_B6 = 8'h01;

  localparam logic [BYTE_W-1:0] UNLOCK_B0 = 8'h60;
  localparam logic [BYTE_W-1:0] UNLOCK_B1 = 8'h06;
  localparam logic [BYTE_W-1:0] UNLOCK_B2 = 8'hC7;
  localparam logic [BYTE_W-1:0] UNLOCK_B3 = 8'h4D;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_WAIT  = 2'd1,
    MODE_MATCH = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_RPM,
    EV_SPEED,
    EV_CLUTCH,
    EV_UP,
    EV_DOWN,
    EV_DOORS
  } ev_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } back_state_t;

  typedef struct packed {
    ev_kind_t          kind;
    logic [RPM_W-1:0]  value;
  } event_t;

  typedef struct packed {
    logic [RPM_W-1:0]    engine_rpm_out;
    logic [GEAR_W-1:0]   gear_estimate;
    logic                target_valid;
    logic [TARGET_W-1:0] rpm_goal;
    logic                welcome_pulse;
    logic                pid_reset_pulse;
    logic                gong_pulse;
    logic                relay_on;
    mode_t               mode_now;
  } result_t;

  // ratio of the next lower gear, indexed by the held gear
  function automatic logic [RATIO_W-1:0] ratio_of(input logic [GEAR_W-1:0] gear);
    logic [RATIO_W-1:0] r;
    unique case (gear)
      3'd2:    r = 8'd130;
      3'd3:    r = 8'd65;
      3'd4:    r = 8'd45;
      3'd5:    r = 8'd32;
      3'd6:    r = 8'd26;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [GEAR_W-1:0] gear_of(input logic [RPM_W-1:0] q);
    logic [GEAR_W-1:0] g;
    priority if (q > 14'd110 && q < 14'd150) g = 3'd1;
    else if (q > 14'd60 && q < 14'd75) g = 3'd2;
    else if (q > 14'd40 && q < 14'd50) g = 3'd3;
    else if (q > 14'd28 && q < 14'd35) g = 3'd4;
    else if (q > 14'd24 && q < 14'd28) g = 3'd5;
    else g = 3'd0;
    return g;
  endfunction

endpackage

// File: rtl/core/rev_match_mode_sequencer.sv
`timescale 1ns / 1ps
// Rev-match mode sequencer.
// Input stream: one received CAN frame per beat. s_tuser is the bus
// (0 body, 1 powertrain); s_tdata carries the identifier and data bytes.
// Output stream: one status beat per frame (mode, relay, beep, controller
// reset and welcome pulses, target rpm, gear estimate, engine rpm).
// Config: cfg_we/cfg_index/cfg_data write the gear floor (0) and max_rpm (1);
// write only while no frame is in flight.
// A decoder in front classifies each frame into an event and pushes it into
// a small queue; the back end pops one event at a time, runs a one-bit-per-
// cycle rpm/speed divider and then the sequencer. Each frame goes through
// load, the divider steps and finish before the next event is loaded.
// Reset clears the control and sensor state (not the data registers)
// and restores gear floor 2 and max_rpm 5000.
// When m_tready is low the finished beat waits in the output register; the
// back end holds its next result and the queue keeps taking frames until
// full, then s_tready drops.

module rev_match_mode_sequencer #(
  parameter int QUEUE_DEPTH = rmms_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rmms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rmms_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // frame_id, byte0 .. byte7, zero pad
  input  logic [rmms_pkg::IN_TDATA_W-1:0]     s_tdata,
  // bus
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // mode_now, relay_on, gong_pulse, pid_reset_pulse, welcome_pulse,
  // target rpm, target_valid, gear_estimate, engine_rpm_out
  output logic [rmms_pkg::OUT_TDATA_W-1:0]    m_tdata
);

  logic              q_full, q_push, q_pop, q_valid;
  rmms_pkg::event_t  push_event, pop_event;
  rmms_pkg::result_t res;

  rmms_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_event  (push_event)
  );

  rmms_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (push_event),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (pop_event),
    .valid (q_valid)
  );

  rmms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_event   (pop_event),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = {res.engine_rpm_out, res.gear_estimate, res.target_valid,
                    res.rpm_goal, res.welcome_pulse, res.pid_reset_pulse,
                    res.gong_pulse, res.relay_on, res.mode_now};

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> q_valid)
    else $error("accepted frame missing from queue");

  a_target_in_match: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[22] |-> m_tdata[1:0] == rmms_pkg::MODE_MATCH)
    else $error("target valid outside rev matching");

  a_pid_with_relay: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> m_tdata[2])
    else $error("controller reset without relay");

  a_no_target_when_invalid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[22] |-> m_tdata[21:6] == '0)
    else $error("target rpm nonzero while invalid");

endmodule

// File: rtl/core/rmms_front.sv
`timescale 1ns / 1ps

module rmms_front (
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [rmms_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic                               s_tuser,
  input  logic                               q_full,
  output logic                               q_push,
  output rmms_pkg::event_t                   q_event
);

  logic [rmms_pkg::ID_W-1:0]   id;
  logic [rmms_pkg::BYTE_W-1:0] b0, b1, b2, b3, b5, b6;

  assign id = s_tdata[10:0];
  assign b0 = s_tdata[18:11];
  assign b1 = s_tdata[26:19];
  assign b2 = s_tdata[34:27];
  assign b3 = s_tdata[42:35];
  assign b5 = s_tdata[58:51];
  assign b6 = s_tdata[66:59];

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_event.kind  = rmms_pkg::EV_NONE;
    q_event.value = '0;
    if (s_tuser) begin
      priority if (id == rmms_pkg::ID_ENGINE) begin
        q_event.kind  = rmms_pkg::EV_RPM;
        q_event.value = {b1, b2[7:2]};
      end else if (id == rmms_pkg::ID_SPEED) begin
        q_event.kind  = rmms_pkg::EV_SPEED;
        q_event.value = {6'd0, b1[6:0], b2[7]};
      end else if (id == rmms_pkg::ID_CLUTCH) begin
        q_event.kind  = rmms_pkg::EV_CLUTCH;
        q_event.value = {13'd0, b1[6]};
      end else begin
        q_event.kind = rmms_pkg::EV_NONE;
      end
    end else begin
      priority if (id == rmms_pkg::ID_BUTTONS) begin
        priority if (b5 == rmms_pkg::BTN_UP_B5 && b6 == rmms_pkg::BTN_UP_B6) begin
          q_event.kind = rmms_pkg::EV_UP;
        end else if (b5 == rmms_pkg::BTN_DN_B5 && b6 == rmms_pkg::BTN_DN_B6) begin
          q_event.kind = rmms_pkg::EV_DOWN;
        end else begin
          q_event.kind = rmms_pkg::EV_NONE;
        end
      end else if (id == rmms_pkg::ID_DOORS) begin
        if (b0 == rmms_pkg::UNLOCK_B0 && b1 == rmms_pkg::UNLOCK_B1 &&
            b2 == rmms_pkg::UNLOCK_B2 && b3 == rmms_pkg::UNLOCK_B3) begin
          q_event.kind = rmms_pkg::EV_DOORS;
        end
      end else begin
        q_event.kind = rmms_pkg::EV_NONE;
      end
    end
  end

endmodule

// File: rtl/core/rmms_queue.sv
`timescale 1ns / 1ps

module rmms_queue #(
  parameter int DEPTH = rmms_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rmms_pkg::event_t  din,
  output logic              full,
  input  logic              pop,
  output rmms_pkg::event_t  dout,
  output logic              valid
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rmms_pkg::event_t slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign dout    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/rmms_back.sv
`timescale 1ns / 1ps

module rmms_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rmms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rmms_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                q_valid,
  input  rmms_pkg::event_t                    q_event,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rmms_pkg::result_t                   out_res
);

  rmms_pkg::back_state_t state, state_next;

  logic [rmms_pkg::GEAR_W-1:0]   gear_floor;
  logic [rmms_pkg::RPM_W-1:0]    max_rpm;
  rmms_pkg::mode_t               mode_reg, mode_next;
  logic [rmms_pkg::RPM_W-1:0]    engine_rpm, engine_rpm_next;
  logic [rmms_pkg::SPEED_W-1:0]  road_speed, road_speed_next;
  logic                          clutch_down, clutch_down_next;
  logic [rmms_pkg::GEAR_W-1:0]   held_gear, held_gear_next;
  logic                          chain_flag, chain_flag_next;
  rmms_pkg::ev_kind_t            ev_kind;

  // restoring divider
  logic [rmms_pkg::RPM_W-1:0]     dvd;
  logic [rmms_pkg::RPM_W-1:0]     quo;
  logic [rmms_pkg::SPEED_W-1:0]   rem;
  logic [rmms_pkg::SPEED_W:0]     rem_sh;
  logic                           rem_ge;
  logic [rmms_pkg::DIV_CNT_W-1:0] cnt;
  logic [rmms_pkg::TARGET_W-1:0]  prod;

  logic                         load, commit, btn;
  logic [rmms_pkg::GEAR_W-1:0]  gear;
  rmms_pkg::result_t            res;

  assign rem_sh = {rem, dvd[rmms_pkg::RPM_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, road_speed});
  assign btn    = (ev_kind == rmms_pkg::EV_UP) || (ev_kind == rmms_pkg::EV_DOWN);
  assign gear   = (road_speed == '0) ? '0 : rmms_pkg::gear_of(quo);

  // state update from the popped event
  always_comb begin
    engine_rpm_next  = engine_rpm;
    road_speed_next  = road_speed;
    clutch_down_next = clutch_down;
    unique case (q_event.kind)
      rmms_pkg::EV_RPM:    engine_rpm_next  = q_event.value;
      rmms_pkg::EV_SPEED:  road_speed_next  = q_event.value[rmms_pkg::SPEED_W-1:0];
      rmms_pkg::EV_CLUTCH: clutch_down_next = q_event.value[0];
      default:             engine_rpm_next  = engine_rpm;
    endcase
  end

  always_comb begin
    state_next = state;
    load       = 1'b0;
    commit     = 1'b0;
    unique case (state)
      rmms_pkg::BK_IDLE: begin
        if (q_valid) begin
          load       = 1'b1;
          state_next = rmms_pkg::BK_DIV;
        end
      end
      rmms_pkg::BK_DIV: begin
        if (cnt == rmms_pkg::DIV_CNT_W'(rmms_pkg::DIV_STEPS - 1)) begin
          state_next = rmms_pkg::BK_FIN;
        end
      end
      rmms_pkg::BK_FIN: begin
        if (!out_valid || out_ready) begin
          commit     = 1'b1;
          state_next = rmms_pkg::BK_IDLE;
        end
      end
      default: state_next = rmms_pkg::BK_IDLE;
    endcase
  end

  assign q_pop = load;

  // mode sequencer
  always_comb begin
    mode_next           = mode_reg;
    held_gear_next      = held_gear;
    chain_flag_next     = chain_flag;
    res.gong_pulse      = 1'b0;
    res.pid_reset_pulse = 1'b0;
    res.welcome_pulse   = 1'b0;
    res.target_valid    = 1'b0;
    res.rpm_goal        = '0;
    unique case (mode_reg)
      rmms_pkg::MODE_WAIT: begin
        if (btn) begin
          mode_next = rmms_pkg::MODE_IDLE;
        end else if (clutch_down) begin
          mode_next           = rmms_pkg::MODE_MATCH;
          res.pid_reset_pulse = 1'b1;
        end
      end
      rmms_pkg::MODE_MATCH: begin
        if (btn || engine_rpm > max_rpm) begin
          res.gong_pulse = 1'b1;
          mode_next      = rmms_pkg::MODE_IDLE;
        end else if (!clutch_down) begin
          res.gong_pulse = 1'b1;
          if (chain_flag && gear > gear_floor) begin
            mode_next = rmms_pkg::MODE_WAIT;
          end else begin
            mode_next       = rmms_pkg::MODE_IDLE;
            chain_flag_next = 1'b0;
          end
        end
        if (mode_next == rmms_pkg::MODE_MATCH) begin
          if (prod > {2'b00, max_rpm}) begin
            res.gong_pulse = 1'b1;
            mode_next      = rmms_pkg::MODE_IDLE;
          end else begin
            res.target_valid = 1'b1;
            res.rpm_goal     = prod;
          end
        end
      end
      default: begin
        mode_next = rmms_pkg::MODE_IDLE;
        if (btn && gear > gear_floor && !clutch_down) begin
          mode_next      = rmms_pkg::MODE_WAIT;
          held_gear_next = gear;
          res.gong_pulse = 1'b1;
          if (ev_kind == rmms_pkg::EV_DOWN) begin
            chain_flag_next = 1'b1;
          end
        end else if (ev_kind == rmms_pkg::EV_DOORS) begin
          res.welcome_pulse = 1'b1;
        end
      end
    endcase
    res.mode_now       = mode_next;
    res.relay_on       = (mode_next == rmms_pkg::MODE_MATCH);
    res.gear_estimate  = gear;
    res.engine_rpm_out = engine_rpm;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= rmms_pkg::BK_IDLE;
      gear_floor  <= rmms_pkg::GEAR_FLOOR_RESET;
      max_rpm     <= rmms_pkg::MAX_RPM_RESET;
      mode_reg    <= rmms_pkg::MODE_IDLE;
      engine_rpm  <= '0;
      road_speed  <= '0;
      clutch_down <= 1'b0;
      held_gear   <= '0;
      chain_flag  <= 1'b0;
      out_valid   <= 1'b0;
      cnt         <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          rmms_pkg::CFG_GEAR_FLOOR: gear_floor <= cfg_data[rmms_pkg::GEAR_W-1:0];
          rmms_pkg::CFG_MAX_RPM:    max_rpm    <= cfg_data;
          default:                  max_rpm    <= max_rpm;
        endcase
      end
      if (load) begin
        engine_rpm  <= engine_rpm_next;
        road_speed  <= road_speed_next;
        clutch_down <= clutch_down_next;
        cnt         <= '0;
      end else if (state == rmms_pkg::BK_DIV) begin
        cnt <= cnt + 1'b1;
      end
      if (commit) begin
        mode_reg   <= mode_next;
        held_gear  <= held_gear_next;
        chain_flag <= chain_flag_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_kind <= q_event.kind;
      dvd     <= engine_rpm_next;
      quo     <= '0;
      rem     <= '0;
    end else if (state == rmms_pkg::BK_DIV) begin
      dvd  <= {dvd[rmms_pkg::RPM_W-2:0], 1'b0};
      quo  <= {quo[rmms_pkg::RPM_W-2:0], rem_ge};
      rem  <= rem_ge ? rmms_pkg::SPEED_W'(rem_sh - {1'b0, road_speed})
                     : rem_sh[rmms_pkg::SPEED_W-1:0];
      prod <= rmms_pkg::TARGET_W'(road_speed) *
              rmms_pkg::TARGET_W'(rmms_pkg::ratio_of(held_gear));
    end
    if (commit) begin
      out_res <= res;
    end
  end

endmodule
